### src/lpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer package
// Shared widths, register indexes and the segment descriptor that travels
// from the classifying front end to the pixel stepping back end.
// ----------------------------------------------------------------------------
package lpr_pkg;

   // Widest coordinate supported internally; ports may be narrower.
   localparam int COORD_W = 6;
   // Width of the screen offset registers.
   localparam int OFF_W   = 7;
   // Width of an emitted pixel coordinate.
   localparam int PIX_W   = 9;

   // Descriptor queue geometry.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_OFFSET = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_OFFSET    = 1'd1;

   // Reset values of the offset registers.
   localparam logic [OFF_W-1:0] COLUMN_OFFSET_RESET = 7'd40;
   localparam logic [OFF_W-1:0] ROW_OFFSET_RESET    = 7'd12;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic        [COORD_W-1:0] mag_type;
   typedef logic        [OFF_W-1:0]   offset_type;
   typedef logic signed [PIX_W-1:0]   pixel_type;

   // One classified segment, ready to be stepped.
   typedef struct packed {
      logic      x_major;      // major axis is x
      logic      major_neg;    // major coordinate steps downward
      logic      minor_neg;    // minor delta is negative
      coord_type start_major;  // major coordinate of the start point
      coord_type start_minor;  // minor coordinate of the start point
      mag_type   count;        // pixels to emit, |major delta|, never zero
      mag_type   minor_abs;    // |minor delta|, never above count
   } desc_type;

   // Screen offsets handed to the back end.
   typedef struct packed {
      offset_type column;
      offset_type row;
   } offsets_type;

endpackage

### src/lpr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer front end
// Takes a segment, works out its deltas and major axis, and pushes a
// descriptor into the queue. Zero-length segments are dropped here.
// ----------------------------------------------------------------------------
module lpr_front #(
   parameter int COORD_BITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic                         queue_full,
   output logic                         queue_push,
   output lpr_pkg::desc_type            queue_desc
);

   lpr_pkg::coord_type              start_x, start_y, end_x, end_y;
   logic signed [lpr_pkg::COORD_W:0] delta_x, delta_y;
   logic        [lpr_pkg::COORD_W:0] abs_x_wide, abs_y_wide;
   lpr_pkg::mag_type                abs_x, abs_y;
   logic                            x_major;

   // Sign-extend the port coordinates to the internal width.
   assign start_x = lpr_pkg::coord_type'(req_start_x);
   assign start_y = lpr_pkg::coord_type'(req_start_y);
   assign end_x   = lpr_pkg::coord_type'(req_end_x);
   assign end_y   = lpr_pkg::coord_type'(req_end_y);

   // Deltas need one extra bit; their magnitudes fit the coordinate width.
   always_comb begin
      delta_x    = {end_x[lpr_pkg::COORD_W-1], end_x} - {start_x[lpr_pkg::COORD_W-1], start_x};
      delta_y    = {end_y[lpr_pkg::COORD_W-1], end_y} - {start_y[lpr_pkg::COORD_W-1], start_y};
      abs_x_wide = delta_x[lpr_pkg::COORD_W] ? -delta_x : delta_x;
      abs_y_wide = delta_y[lpr_pkg::COORD_W] ? -delta_y : delta_y;
      abs_x      = abs_x_wide[lpr_pkg::COORD_W-1:0];
      abs_y      = abs_y_wide[lpr_pkg::COORD_W-1:0];
      x_major    = abs_y <= abs_x;
   end

   // Build the descriptor; a tie of the deltas counts as x-major.
   always_comb begin
      queue_desc.x_major = x_major;
      if (x_major) begin
         queue_desc.major_neg   = delta_x[lpr_pkg::COORD_W];
         queue_desc.minor_neg   = delta_y[lpr_pkg::COORD_W];
         queue_desc.start_major = start_x;
         queue_desc.start_minor = start_y;
         queue_desc.count       = abs_x;
         queue_desc.minor_abs   = abs_y;
      end else begin
         queue_desc.major_neg   = delta_y[lpr_pkg::COORD_W];
         queue_desc.minor_neg   = delta_x[lpr_pkg::COORD_W];
         queue_desc.start_major = start_y;
         queue_desc.start_minor = start_x;
         queue_desc.count       = abs_y;
         queue_desc.minor_abs   = abs_x;
      end
   end

   // A transaction is taken whenever the queue has room; empty segments
   // are accepted but never queued.
   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full && (queue_desc.count != '0);

   // The queue must never be pushed while full.
   assert property (@(posedge clock) disable iff (reset) queue_push |-> !queue_full)
      else $error("front pushed into a full queue");

   // A queued segment is never longer along its minor axis than its major one.
   assert property (@(posedge clock) disable iff (reset)
      queue_push |-> (queue_desc.minor_abs <= queue_desc.count))
      else $error("minor delta exceeds major delta");

   // Only a zero-length segment is dropped.
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && !queue_push) |->
         (delta_x == '0 && delta_y == '0))
      else $error("non-empty segment dropped");

endmodule

### src/lpr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer descriptor queue
// A short first-in first-out buffer of segment descriptors that lets the
// front end and the back end stall independently.
// ----------------------------------------------------------------------------
module lpr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpr_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output lpr_pkg::desc_type pop_desc
);

   lpr_pkg::desc_type                entry_ff [lpr_pkg::QUEUE_DEPTH];
   logic [lpr_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [lpr_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [lpr_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full     = count_ff == lpr_pkg::QCNT_W'(lpr_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_desc = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // Occupancy never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= lpr_pkg::QCNT_W'(lpr_pkg::QUEUE_DEPTH))
      else $error("queue overfilled");

   // No pop from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");

   // Pointers differ exactly when the queue is neither empty nor full.
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) == (empty || full))
      else $error("queue pointers inconsistent with count");

endmodule

### src/lpr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer back end
// Steps one segment at a time, a pixel per cycle unless the output stalls. The minor
// coordinate is the exact ceiling of minor_delta * k / count, kept as a running
// quotient and remainder so each step needs only one add and one compare-subtract.
// ----------------------------------------------------------------------------
module lpr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  lpr_pkg::desc_type    queue_desc,
   output logic                 queue_pop,
   input  lpr_pkg::offsets_type offsets,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output lpr_pkg::pixel_type   rsp_pixel_column,
   output lpr_pkg::pixel_type   rsp_pixel_row,
   output logic                 rsp_last_pixel
);

   localparam int CW = lpr_pkg::COORD_W;

   // Segment stepping state.
   logic                       busy_ff, busy_in;
   lpr_pkg::desc_type          desc_ff, desc_in;
   lpr_pkg::mag_type           step_ff, step_in;
   lpr_pkg::mag_type           quot_ff, quot_in;
   lpr_pkg::mag_type           rem_ff, rem_in;

   // Output register.
   logic                       out_valid_ff, out_valid_in;
   lpr_pkg::pixel_type         column_ff, column_in;
   lpr_pkg::pixel_type         row_ff, row_in;
   logic                       last_ff, last_in;

   logic                       advance;
   logic                       final_step;
   logic [CW:0]                rem_sum, rem_sub;
   logic                       rem_wrap;
   logic signed [CW:0]         major_start, minor_start, step_ext, quot_ext;
   logic signed [CW:0]         major_pos, minor_pos, x_pos, y_pos;

   // A pixel moves into the output register when it is free or being drained.
   assign advance    = busy_ff && (!out_valid_ff || rsp_pop);
   assign final_step = step_ff == desc_ff.count - 1'b1;
   assign queue_pop  = !busy_ff && !queue_empty;

   // Coordinates of the current pixel.
   always_comb begin
      major_start = {desc_ff.start_major[CW-1], desc_ff.start_major};
      minor_start = {desc_ff.start_minor[CW-1], desc_ff.start_minor};
      step_ext    = {1'b0, step_ff};
      quot_ext    = {1'b0, quot_ff};
      major_pos   = desc_ff.major_neg ? major_start - step_ext : major_start + step_ext;
      minor_pos   = desc_ff.minor_neg ? minor_start - quot_ext : minor_start + quot_ext;
      x_pos       = desc_ff.x_major ? major_pos : minor_pos;
      y_pos       = desc_ff.x_major ? minor_pos : major_pos;
   end

   // Running remainder; it stays below count, so one subtract suffices.
   always_comb begin
      rem_sum  = {1'b0, rem_ff} + {1'b0, desc_ff.minor_abs};
      rem_sub  = rem_sum - {1'b0, desc_ff.count};
      rem_wrap = rem_sum >= {1'b0, desc_ff.count};
   end

   // Segment sequencing.
   always_comb begin
      busy_in = busy_ff;
      desc_in = desc_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (queue_pop) begin
         // Ceiling bias: a positive minor delta starts at count - 1.
         busy_in = 1'b1;
         desc_in = queue_desc;
         step_in = '0;
         quot_in = '0;
         rem_in  = queue_desc.minor_neg ? '0 : queue_desc.count - 1'b1;
      end else if (advance) begin
         if (final_step) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
            quot_in = rem_wrap ? quot_ff + 1'b1 : quot_ff;
            rem_in  = rem_wrap ? rem_sub[CW-1:0] : rem_sum[CW-1:0];
         end
      end
   end

   // Output register load and drain.
   always_comb begin
      out_valid_in = out_valid_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      last_in      = last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         column_in    = {{(lpr_pkg::PIX_W-CW-1){x_pos[CW]}}, x_pos}
                      + {{(lpr_pkg::PIX_W-lpr_pkg::OFF_W){1'b0}}, offsets.column};
         row_in       = {{(lpr_pkg::PIX_W-CW-1){y_pos[CW]}}, y_pos}
                      + {{(lpr_pkg::PIX_W-lpr_pkg::OFF_W){1'b0}}, offsets.row};
         last_in      = final_step;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff   <= desc_in;
      step_ff   <= step_in;
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      column_ff <= column_in;
      row_ff    <= row_in;
      last_ff   <= last_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_pixel_column = column_ff;
   assign rsp_pixel_row    = row_ff;
   assign rsp_last_pixel   = last_ff;

   // The step index stays inside the segment.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> step_ff < desc_ff.count)
      else $error("step index past segment end");

   // The remainder stays below the divisor.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> rem_ff < desc_ff.count)
      else $error("remainder out of range");

   // The minor offset never passes the minor delta.
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> quot_ff <= desc_ff.minor_abs)
      else $error("minor offset overshoot");

   // After the final pixel of a segment is issued the back end goes idle.
   assert property (@(posedge clock) disable iff (reset)
      (advance && final_step) |=> (!busy_ff && out_valid_ff && last_ff))
      else $error("segment did not close on its last pixel");

endmodule

### src/line_pixel_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer
// Converts a line segment into the screen pixels that draw it, start point
// included and end point excluded, with a mark on each segment's last pixel.
// ----------------------------------------------------------------------------
// Usage: a segment of n pixels (n = larger of |dx| and |dy|) occupies the
// stepping back end for a load step and then its n pixels, one pixel per
// cycle while the result side keeps popping. The front end takes a segment
// per cycle as long as the two-entry descriptor queue has room, and
// zero-length segments are taken and produce no transaction. Offsets
// written through the csr port apply to pixels issued after the write and
// should only be changed while idle.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer #(
   parameter int COORD_BITS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   // Segment input
   input  logic                               push,
   output logic                               full,
   input  logic signed [COORD_BITS-1:0]       req_start_x,
   input  logic signed [COORD_BITS-1:0]       req_start_y,
   input  logic signed [COORD_BITS-1:0]       req_end_x,
   input  logic signed [COORD_BITS-1:0]       req_end_y,
   // Pixel output
   output logic                               empty,
   input  logic                               pop,
   output logic signed [lpr_pkg::PIX_W-1:0]   rsp_pixel_column,
   output logic signed [lpr_pkg::PIX_W-1:0]   rsp_pixel_row,
   output logic                               rsp_last_pixel,
   // Configuration
   input  logic                               csr_wr_en,
   input  logic [lpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lpr_pkg::OFF_W-1:0]          csr_wdata
);

   lpr_pkg::offset_type  column_offset_ff, column_offset_in;
   lpr_pkg::offset_type  row_offset_ff, row_offset_in;
   lpr_pkg::offsets_type offsets;
   lpr_pkg::desc_type    push_desc, pop_desc;
   logic                 queue_push, queue_pop, queue_full, queue_empty;

   // Offset register writes.
   always_comb begin
      column_offset_in = column_offset_ff;
      row_offset_in    = row_offset_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lpr_pkg::CSR_COLUMN_OFFSET: column_offset_in = csr_wdata;
            lpr_pkg::CSR_ROW_OFFSET:    row_offset_in    = csr_wdata;
            default: begin
               column_offset_in = column_offset_ff;
               row_offset_in    = row_offset_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= lpr_pkg::COLUMN_OFFSET_RESET;
         row_offset_ff    <= lpr_pkg::ROW_OFFSET_RESET;
      end else begin
         column_offset_ff <= column_offset_in;
         row_offset_ff    <= row_offset_in;
      end
   end

   assign offsets.column = column_offset_ff;
   assign offsets.row    = row_offset_ff;

   // Classify incoming segments.
   lpr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (push),
      .req_full    (full),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_desc  (push_desc)
   );

   // Decouple front and back.
   lpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_desc (push_desc),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_desc  (pop_desc)
   );

   // Step pixels out.
   lpr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_desc       (pop_desc),
      .queue_pop        (queue_pop),
      .offsets          (offsets),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

### tb/lpr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer checker
// Watches the segment, pixel and csr ports. For every accepted segment it
// works out the pixels the rasterizer must emit and compares each accepted
// pixel transaction, field by field, against the oldest one still pending.
// ----------------------------------------------------------------------------
module lpr_checker
   import lpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 full,
   input  coord_type            req_start_x,
   input  coord_type            req_start_y,
   input  coord_type            req_end_x,
   input  coord_type            req_end_y,
   input  logic                 empty,
   input  logic                 pop,
   input  pixel_type            rsp_pixel_column,
   input  pixel_type            rsp_pixel_row,
   input  logic                 rsp_last_pixel,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  offset_type           csr_wdata,
   output int                   pixels_pending,
   output int                   fail_count
);

   // One predicted pixel transaction.
   typedef struct packed {
      pixel_type column;
      pixel_type row;
      logic      last;
   } pixel_rec;

   pixel_rec   pending_pixels[$];
   offset_type column_offset;
   offset_type row_offset;
   int         failures;

   initial begin
      pixels_pending = 0;
      fail_count     = 0;
      failures       = 0;
      column_offset  = COLUMN_OFFSET_RESET;
      row_offset     = ROW_OFFSET_RESET;
   end

   // Ceiling of num / den for a positive den, exact for either sign of num.
   function automatic int ceil_quotient(input int num, input int den);
      if (num >= 0) begin
         return (num + den - 1) / den;
      end
      return -((-num) / den);
   endfunction

   // Queue the pixels of one segment: the major axis steps one unit per
   // pixel, the minor axis follows the exact rational ceiling, and the end
   // point itself is left out.
   function automatic void rasterize_segment(input coord_type sx, input coord_type sy,
                                             input coord_type ex, input coord_type ey);
      int       dx;
      int       dy;
      int       abs_dx;
      int       abs_dy;
      int       steps;
      int       px;
      int       py;
      logic     x_major;
      pixel_rec rec;
      dx      = int'(ex) - int'(sx);
      dy      = int'(ey) - int'(sy);
      abs_dx  = (dx < 0) ? -dx : dx;
      abs_dy  = (dy < 0) ? -dy : dy;
      x_major = (abs_dy <= abs_dx);
      steps   = x_major ? abs_dx : abs_dy;
      for (int k = 0; k < steps; k++) begin
         if (x_major) begin
            px = int'(sx) + ((dx > 0) ? k : -k);
            py = int'(sy) + ceil_quotient(dy * k, steps);
         end else begin
            py = int'(sy) + ((dy > 0) ? k : -k);
            px = int'(sx) + ceil_quotient(dx * k, steps);
         end
         px         = px + int'(column_offset);
         py         = py + int'(row_offset);
         rec.column = px[PIX_W-1:0];
         rec.row    = py[PIX_W-1:0];
         rec.last   = (k == steps - 1);
         pending_pixels.push_back(rec);
      end
   endfunction

   // Track the offsets, check emitted pixels, then predict new segments.
   // A pixel can never come from a segment taken at the same edge, so the
   // check runs before the prediction.
   always @(posedge clock) begin
      pixel_rec want;
      if (reset) begin
         column_offset = COLUMN_OFFSET_RESET;
         row_offset    = ROW_OFFSET_RESET;
         pending_pixels.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_COLUMN_OFFSET: begin
                  column_offset = csr_wdata;
               end
               CSR_ROW_OFFSET: begin
                  row_offset = csr_wdata;
               end
               default: begin
               end
            endcase
         end

         if (pop && !empty) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel transaction with none pending: column %0d row %0d last %0b",
                      rsp_pixel_column, rsp_pixel_row, rsp_last_pixel);
               failures++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_column !== want.column) begin
                  $error("pixel_column: expected %0d, actual %0d",
                         want.column, rsp_pixel_column);
                  failures++;
               end
               if (rsp_pixel_row !== want.row) begin
                  $error("pixel_row: expected %0d, actual %0d", want.row, rsp_pixel_row);
                  failures++;
               end
               if (rsp_last_pixel !== want.last) begin
                  $error("last_pixel: expected %0b, actual %0b", want.last, rsp_last_pixel);
                  failures++;
               end
            end
         end

         if (push && !full) begin
            rasterize_segment(req_start_x, req_start_y, req_end_x, req_end_y);
         end
      end
      pixels_pending <= pending_pixels.size();
      fail_count     <= failures;
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer testbench
// Drives segments in bursts under a pixel consumer that stalls on its own
// pattern, steps through several screen offset settings, and lets the
// checker score every pixel transaction.
// ----------------------------------------------------------------------------
module tb_top;
   import lpr_pkg::*;

   localparam int PERIOD_HALF   = 10;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 56;

   typedef enum logic [2:0] {
      SEG_ANY,
      SEG_SHORT,
      SEG_DIAGONAL,
      SEG_AXIS,
      SEG_POINT
   } seg_kind_type;

   typedef enum logic [1:0] {
      SINK_STREAM,
      SINK_COIN,
      SINK_SPARSE,
      SINK_HOLD
   } sink_mode_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   coord_type            req_start_x = '0;
   coord_type            req_start_y = '0;
   coord_type            req_end_x = '0;
   coord_type            req_end_y = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   pixel_type            rsp_pixel_column;
   pixel_type            rsp_pixel_row;
   logic                 rsp_last_pixel;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_COLUMN_OFFSET;
   offset_type           csr_wdata = '0;
   int                   pixels_pending;
   int                   fail_count;
   int                   burst_left = 0;
   sink_mode_type        sink_state = SINK_STREAM;
   int                   sink_left = 0;

   line_pixel_rasterizer #(
      .COORD_BITS(COORD_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_column(rsp_pixel_column),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   lpr_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .empty           (empty),
      .pop             (pop),
      .rsp_pixel_column(rsp_pixel_column),
      .rsp_pixel_row   (rsp_pixel_row),
      .rsp_last_pixel  (rsp_last_pixel),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pixels_pending  (pixels_pending),
      .fail_count      (fail_count)
   );

   // Free-running clock.
   always begin
      #PERIOD_HALF clock = 1'b1;
      #PERIOD_HALF clock = 1'b0;
   end

   // Pixel consumer: switches between streaming, coin-flip, sparse and hold
   // modes for random stretches.
   always @(posedge clock) begin
      logic take;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (sink_left == 0) begin
            sink_state = sink_mode_type'($urandom_range(0, 3));
            sink_left  = (sink_state == SINK_HOLD) ? $urandom_range(1, 40)
                                                   : $urandom_range(1, 150);
         end
         sink_left--;
         case (sink_state)
            SINK_STREAM: begin
               take = 1'b1;
            end
            SINK_COIN: begin
               take = ($urandom_range(0, 1) == 1);
            end
            SINK_SPARSE: begin
               take = ($urandom_range(0, 3) == 0);
            end
            default: begin
               take = 1'b0;
            end
         endcase
         pop <= take;
      end
   end

   // Ends the run if no transaction moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("line_pixel_rasterizer verification failed");
      $finish;
   end

   // Offer one segment and hold it until taken, then end the burst with a
   // random gap when its length runs out.
   task automatic issue_segment(input coord_type sx, input coord_type sy,
                                input coord_type ex, input coord_type ey);
      int gap;
      push        <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x   <= ex;
      req_end_y   <= ey;
      @(posedge clock);
      while (full) begin
         @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering segments and wait until every pending pixel has come,
   // plus a settle time for segments that emit nothing.
   task automatic wait_drained(input int settle);
      push <= 1'b0;
      do begin
         @(negedge clock);
      end while (pixels_pending != 0);
      repeat (settle) @(negedge clock);
   endtask

   // Write one offset register; only called while the rasterizer is idle.
   // The enable is lowered again after each write before the task returns.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input offset_type value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Field extremes, all four directions on both axes, ties, single pixels
   // and zero-length segments.
   task automatic directed_segments();
      issue_segment(-32, -32,  31,  31);
      issue_segment( 31,  31, -32, -32);
      issue_segment(-32,  31,  31, -32);
      issue_segment( 31, -32, -32,  31);
      issue_segment(-32,   0,  31,   0);
      issue_segment( 31,   5, -32,   5);
      issue_segment(  0, -32,   0,  31);
      issue_segment(  3,  31,   3, -32);
      issue_segment(  5,   5,   5,   5);
      issue_segment(-32, -32, -32, -32);
      issue_segment(  0,   0,   1,   0);
      issue_segment(  0,   0,   0,  -1);
      issue_segment(  0,   0,   1,   1);
      issue_segment(-32, -32,  31, -31);
      issue_segment(-32, -32, -31,  31);
      issue_segment( 10,  -3, -20,   7);
      issue_segment( -5,  20,   2, -25);
      issue_segment(-32,  31,  31,  30);
      issue_segment(  7,  -9,  -8,  12);
      issue_segment( 31,  31,  30, -32);
      issue_segment(  0,   0,  -3,   2);
      issue_segment( -1,  -1, -31,  -2);
   endtask

   // Random segments of mixed shapes; zero-length ones are extra. Halfway
   // through, the sender waits for every pending pixel.
   task automatic random_segments(input int count);
      int           drawn;
      int           pick;
      int           span;
      int           xs;
      int           ys;
      int           xe;
      int           ye;
      seg_kind_type kind;
      drawn = 0;
      while (drawn < count) begin
         pick = $urandom_range(0, 99);
         kind = (pick < 50) ? SEG_ANY : (pick < 65) ? SEG_SHORT :
                (pick < 77) ? SEG_DIAGONAL : (pick < 90) ? SEG_AXIS : SEG_POINT;
         xs = int'($urandom_range(0, 63)) - 32;
         ys = int'($urandom_range(0, 63)) - 32;
         xe = int'($urandom_range(0, 63)) - 32;
         ye = int'($urandom_range(0, 63)) - 32;
         case (kind)
            SEG_SHORT: begin
               xs = int'($urandom_range(0, 55)) - 28;
               ys = int'($urandom_range(0, 55)) - 28;
               xe = xs + int'($urandom_range(0, 8)) - 4;
               ye = ys + int'($urandom_range(0, 8)) - 4;
            end
            SEG_DIAGONAL: begin
               span = $urandom_range(1, 63);
               xs   = int'($urandom_range(0, 63 - span)) - 32;
               xe   = xs + span;
               ys   = int'($urandom_range(0, 63 - span)) - 32;
               ye   = ys + span;
               if ($urandom_range(0, 1)) begin
                  xe = xs;
                  xs = xs + span;
               end
               if ($urandom_range(0, 1)) begin
                  ye = ys;
                  ys = ys + span;
               end
            end
            SEG_AXIS: begin
               if ($urandom_range(0, 1)) begin
                  ye = ys;
               end else begin
                  xe = xs;
               end
            end
            SEG_POINT: begin
               xe = xs;
               ye = ys;
            end
            default: begin
            end
         endcase
         issue_segment(coord_type'(xs), coord_type'(ys), coord_type'(xe), coord_type'(ye));
         if ((xs != xe) || (ys != ye)) begin
            drawn++;
            if (drawn == count / 2) begin
               wait_drained(0);
               @(posedge clock);
            end
         end
      end
   endtask

   // Reset, then one phase per offset setting, extremes first.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Offsets at their reset values.
      directed_segments();
      random_segments(20);
      wait_drained(SETTLE_CYCLES);
      @(posedge clock);

      // Both offsets at zero.
      write_csr(CSR_COLUMN_OFFSET, 7'd0);
      write_csr(CSR_ROW_OFFSET, 7'd0);
      random_segments(PHASE_ITEMS);
      wait_drained(SETTLE_CYCLES);
      @(posedge clock);

      // Both offsets at their maximum, with the corner cases again.
      write_csr(CSR_COLUMN_OFFSET, 7'd127);
      write_csr(CSR_ROW_OFFSET, 7'd127);
      directed_segments();
      random_segments(PHASE_ITEMS);
      wait_drained(SETTLE_CYCLES);
      @(posedge clock);

      // Mixed extremes.
      write_csr(CSR_COLUMN_OFFSET, 7'd0);
      write_csr(CSR_ROW_OFFSET, 7'd127);
      random_segments(PHASE_ITEMS);
      wait_drained(SETTLE_CYCLES);
      @(posedge clock);

      write_csr(CSR_ROW_OFFSET, 7'd0);
      write_csr(CSR_COLUMN_OFFSET, 7'd127);
      random_segments(PHASE_ITEMS);
      wait_drained(SETTLE_CYCLES);
      @(posedge clock);

      // Random offsets.
      write_csr(CSR_COLUMN_OFFSET, offset_type'($urandom_range(0, 127)));
      write_csr(CSR_ROW_OFFSET, offset_type'($urandom_range(0, 127)));
      random_segments(PHASE_ITEMS);
      wait_drained(SETTLE_CYCLES);

      if (fail_count == 0) begin
         $display("line_pixel_rasterizer verification clean");
      end else begin
         $display("line_pixel_rasterizer verification failed");
      end
      $finish;
   end

endmodule

### sim.f
src/lpr_pkg.sv
src/lpr_front.sv
src/lpr_queue.sv
src/lpr_back.sv
src/line_pixel_rasterizer.sv
tb/lpr_checker.sv
tb/tb_top.sv
